### design/tpik_pkg.sv
// ----------------------------------------------------------------------------
// tpik_pkg
// Shared types, constants and the arctangent table for the tilt platform
// inverse kinematics pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tpik_pkg;

   localparam int ANGLE_FRAC_BITS_DEF = 8;
   localparam int FIELD_W = 16;

   localparam int CORDIC_STEPS = 20;
   localparam int DIV_STEPS = 30;
   localparam int SQRT_STEPS = 31;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   // angles in degrees with 16 fraction bits
   localparam int ANG_W = 30;
   localparam int DEG_FULL = 23592960;
   localparam int DEG_HALF = 11796480;
   localparam int DEG_QUARTER = 5898240;

   localparam int CORDIC_W = 34;
   localparam int CORDIC_Z_W = 27;
   localparam int CORDIC_GAIN = 652032874;
   localparam int HALF_SQRT3 = 929887697;

   localparam int SIN_W = 32;
   localparam int T1_W = 49;
   localparam int P_W = 64;
   localparam int LAQ_W = 50;
   localparam int LA_W = 28;
   localparam int SQ_W = 56;
   localparam int CR_W = 45;
   localparam int NUM_W = 58;
   localparam int DEN_W = 54;
   localparam int AN_W = 57;
   localparam int AD_W = 53;
   localparam int REM_W = AD_W + 1;
   localparam int Q_W = 30;
   localparam int R_W = 32;
   localparam int SQ_V_W = 61;
   localparam int SQ_RES_W = 62;

   localparam logic signed [FIELD_W-1:0] SERVO_MAX = 16'sh7fff;
   localparam logic signed [FIELD_W-1:0] SERVO_MIN = 16'sh8000;

   typedef enum logic [1:0] {
      REG_UPPER_ARM    = 2'd0,
      REG_LOWER_LINK   = 2'd1,
      REG_REST_HEIGHT  = 2'd2,
      REG_JOINT_RADIUS = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic signed [CORDIC_W-1:0]   x;
      logic signed [CORDIC_W-1:0]   y;
      logic signed [CORDIC_Z_W-1:0] z;
      logic                         flag;
   } cordic_lane_type;

   typedef struct packed {
      logic [REM_W-1:0] rem;
      logic [AD_W-1:0]  den;
      logic [Q_W-1:0]   q;
      logic             neg;
      logic             full;
      logic             bad;
   } div_lane_type;

   typedef struct packed {
      logic [SQ_V_W-1:0]       v;
      logic [SQ_RES_W-1:0]     res;
      logic signed [R_W-1:0]   r;
      logic                    bad;
   } sqrt_lane_type;

   // atan(2^-i) in degrees, 16 fraction bits
   function automatic logic signed [CORDIC_Z_W-1:0] atan_deg(input int unsigned step);
      case (step)
         0:       return 27'sd2949120;
         1:       return 27'sd1740967;
         2:       return 27'sd919879;
         3:       return 27'sd466945;
         4:       return 27'sd234379;
         5:       return 27'sd117304;
         6:       return 27'sd58666;
         7:       return 27'sd29335;
         8:       return 27'sd14668;
         9:       return 27'sd7334;
         10:      return 27'sd3667;
         11:      return 27'sd1833;
         12:      return 27'sd917;
         13:      return 27'sd458;
         14:      return 27'sd229;
         15:      return 27'sd115;
         16:      return 27'sd57;
         17:      return 27'sd29;
         18:      return 27'sd14;
         19:      return 27'sd7;
         default: return '0;
      endcase
   endfunction

endpackage

### design/tpik_ifs.sv
// ----------------------------------------------------------------------------
// tpik channel interfaces
// Valid/ready channels for pose items and servo result items.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface tpik_req_if;
   logic                                    valid;
   logic                                    ready;
   logic signed [tpik_pkg::FIELD_W-1:0]     roll_angle;
   logic signed [tpik_pkg::FIELD_W-1:0]     pitch_angle;

   modport source (output valid, output roll_angle, output pitch_angle, input ready);
   modport sink (input valid, input roll_angle, input pitch_angle, output ready);
endinterface

interface tpik_rsp_if;
   logic                                    valid;
   logic                                    ready;
   logic signed [tpik_pkg::FIELD_W-1:0]     servo_a;
   logic signed [tpik_pkg::FIELD_W-1:0]     servo_b;
   logic signed [tpik_pkg::FIELD_W-1:0]     servo_c;
   logic                                    invalid;

   modport source (output valid, output servo_a, output servo_b, output servo_c,
                   output invalid, input ready);
   modport sink (input valid, input servo_a, input servo_b, input servo_c,
                 input invalid, output ready);
endinterface

### design/tilt_platform_inverse_kinematics.sv
// ----------------------------------------------------------------------------
// tilt_platform_inverse_kinematics
// Servo angles of a three-arm tilting plate from roll and pitch, fully
// pipelined through chains of CORDIC, divider and square-root cells.
// ----------------------------------------------------------------------------
// throughput: one item per cycle; the whole chain holds while a result waits
// the chain length is set by 20 sine cells, 30 divider cells, 31 root cells
// and 20 arctangent cells in series
// reset clears the length registers and all valid flags, no clearing pass
`timescale 1ns / 1ps

module tilt_platform_inverse_kinematics #(
   parameter int ANGLE_FRAC_BITS = tpik_pkg::ANGLE_FRAC_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   tpik_req_if.sink                           req_chan,
   tpik_rsp_if.source                         rsp_chan,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [tpik_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [tpik_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [tpik_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                               pready
);

   localparam int SHIFT = tpik_pkg::FIELD_W - ANGLE_FRAC_BITS;
   localparam int ROUND_ADD = (SHIFT > 0) ? (1 << (SHIFT - 1)) : 0;
   localparam int OUT_Z_W = tpik_pkg::CORDIC_Z_W + 1;
   localparam int LATENCY = 14 + 2 * tpik_pkg::CORDIC_STEPS + tpik_pkg::DIV_STEPS
                            + tpik_pkg::SQRT_STEPS;
   localparam int ANG_W = tpik_pkg::ANG_W;
   localparam logic [ANG_W-1:0] FULL_U = ANG_W'(tpik_pkg::DEG_FULL);
   localparam logic signed [ANG_W-1:0] FULL_S = ANG_W'(tpik_pkg::DEG_FULL);
   localparam logic signed [ANG_W-1:0] HALF_S = ANG_W'(tpik_pkg::DEG_HALF);
   localparam logic signed [ANG_W-1:0] QUARTER_S = ANG_W'(tpik_pkg::DEG_QUARTER);
   localparam logic signed [tpik_pkg::P_W-1:0] HALF_SQRT3_S =
      tpik_pkg::P_W'(tpik_pkg::HALF_SQRT3);

   // configuration registers
   logic [15:0] upper_arm_length_ff, lower_link_length_ff;
   logic [15:0] plate_rest_height_ff, joint_circle_radius_ff;
   tpik_pkg::csr_index_type csr_index;
   logic csr_write;

   assign csr_index = tpik_pkg::csr_index_type'(paddr[3:2]);
   assign csr_write = psel && penable && pwrite;
   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         upper_arm_length_ff <= '0;
         lower_link_length_ff <= '0;
         plate_rest_height_ff <= '0;
         joint_circle_radius_ff <= '0;
      end else if (csr_write) begin
         case (csr_index)
            tpik_pkg::REG_UPPER_ARM:    upper_arm_length_ff <= pwdata[15:0];
            tpik_pkg::REG_LOWER_LINK:   lower_link_length_ff <= pwdata[15:0];
            tpik_pkg::REG_REST_HEIGHT:  plate_rest_height_ff <= pwdata[15:0];
            tpik_pkg::REG_JOINT_RADIUS: joint_circle_radius_ff <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         tpik_pkg::REG_UPPER_ARM:    prdata = {16'd0, upper_arm_length_ff};
         tpik_pkg::REG_LOWER_LINK:   prdata = {16'd0, lower_link_length_ff};
         tpik_pkg::REG_REST_HEIGHT:  prdata = {16'd0, plate_rest_height_ff};
         tpik_pkg::REG_JOINT_RADIUS: prdata = {16'd0, joint_circle_radius_ff};
         default:                    prdata = '0;
      endcase
   end

   // chain control
   logic en;
   logic [LATENCY-1:0] valid_ff;

   assign en = !valid_ff[LATENCY-1] || rsp_chan.ready;
   assign req_chan.ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[LATENCY-2:0], req_chan.valid};
      end
   end

   // angle entry, wrap and fold
   logic signed [ANG_W-1:0] ang_in [2];
   logic signed [ANG_W-1:0] ang_ff [2];
   logic signed [ANG_W-1:0] red_in [2];
   logic signed [ANG_W-1:0] red_ff [2];
   logic [ANG_W-1:0]        red_m [2];
   logic signed [ANG_W-1:0] fold_v [2];
   tpik_pkg::cordic_lane_type rot_in [2];
   tpik_pkg::cordic_lane_type rot_chain [2][tpik_pkg::CORDIC_STEPS+1];
   logic signed [tpik_pkg::SIN_W-1:0] sin_in [2];
   logic signed [tpik_pkg::SIN_W-1:0] sin_ff [2];

   assign ang_in[0] = ANG_W'(req_chan.roll_angle) <<< SHIFT;
   assign ang_in[1] = ANG_W'(req_chan.pitch_angle) <<< SHIFT;

   for (genvar g = 0; g < 2; g++) begin : g_sine
      always_comb begin
         red_m[g] = ang_ff[g][ANG_W-1] ? ANG_W'(-ang_ff[g]) : ang_ff[g];
         for (int k = 2; k >= 0; k--) begin
            if (red_m[g] >= (FULL_U << k)) begin
               red_m[g] = red_m[g] - (FULL_U << k);
            end
         end
         red_in[g] = ang_ff[g][ANG_W-1] ? -signed'(red_m[g]) : signed'(red_m[g]);
      end

      always_comb begin
         fold_v[g] = red_ff[g];
         if (fold_v[g] >= HALF_S) begin
            fold_v[g] = fold_v[g] - FULL_S;
         end
         if (fold_v[g] < -HALF_S) begin
            fold_v[g] = fold_v[g] + FULL_S;
         end
         if (fold_v[g] > QUARTER_S) begin
            fold_v[g] = HALF_S - fold_v[g];
         end
         if (fold_v[g] < -QUARTER_S) begin
            fold_v[g] = -HALF_S - fold_v[g];
         end
         rot_in[g].x = tpik_pkg::CORDIC_W'(tpik_pkg::CORDIC_GAIN);
         rot_in[g].y = '0;
         rot_in[g].z = tpik_pkg::CORDIC_Z_W'(fold_v[g]);
         rot_in[g].flag = 1'b0;
      end

      always_ff @(posedge clock) begin
         if (en) begin
            ang_ff[g] <= ang_in[g];
            red_ff[g] <= red_in[g];
            rot_chain[g][0] <= rot_in[g];
            sin_ff[g] <= sin_in[g];
         end
      end

      for (genvar s = 0; s < tpik_pkg::CORDIC_STEPS; s++) begin : g_cell
         tpik_cordic_cell #(
            .STEP   (s),
            .VECTOR (1'b0)
         ) u_cell (
            .clock    (clock),
            .enable   (en),
            .cell_in  (rot_chain[g][s]),
            .cell_out (rot_chain[g][s+1])
         );
      end

      always_comb begin
         if (rot_chain[g][tpik_pkg::CORDIC_STEPS].y > (tpik_pkg::CORDIC_W'(1) <<< 30)) begin
            sin_in[g] = tpik_pkg::SIN_W'(1) <<< 30;
         end else if (rot_chain[g][tpik_pkg::CORDIC_STEPS].y < -(tpik_pkg::CORDIC_W'(1) <<< 30)) begin
            sin_in[g] = -(tpik_pkg::SIN_W'(1) <<< 30);
         end else begin
            sin_in[g] = tpik_pkg::SIN_W'(rot_chain[g][tpik_pkg::CORDIC_STEPS].y);
         end
      end
   end

   // joint heights
   logic signed [16:0] rr_s;
   logic signed [tpik_pkg::T1_W-1:0] t1_ff, t1d_ff, t3_ff;
   logic signed [tpik_pkg::P_W-1:0] p_ff;
   logic signed [tpik_pkg::SIN_W-1:0] s3;
   logic signed [tpik_pkg::LAQ_W-1:0] base, half_t1;
   logic signed [tpik_pkg::LAQ_W-1:0] laq_in [3];
   logic signed [tpik_pkg::LAQ_W-1:0] laq_ff [3];
   logic signed [tpik_pkg::LA_W-1:0] la_ff [3];
   logic signed [tpik_pkg::SQ_W-1:0] sq_ff [3];
   logic signed [tpik_pkg::CR_W-1:0] cr_ff [3];
   logic [31:0] l1sq_ff, l2sq_ff;

   assign rr_s = signed'({1'b0, joint_circle_radius_ff});
   assign s3 = tpik_pkg::SIN_W'(p_ff >>> 30);
   assign base = tpik_pkg::LAQ_W'(signed'({1'b0, plate_rest_height_ff})) <<< 30;
   assign half_t1 = tpik_pkg::LAQ_W'(t1d_ff >>> 1);
   assign laq_in[0] = base + tpik_pkg::LAQ_W'(t1d_ff);
   assign laq_in[1] = base - half_t1 + tpik_pkg::LAQ_W'(t3_ff);
   assign laq_in[2] = base - half_t1 - tpik_pkg::LAQ_W'(t3_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         t1_ff <= tpik_pkg::T1_W'(rr_s) * tpik_pkg::T1_W'(sin_ff[0]);
         p_ff <= tpik_pkg::P_W'(sin_ff[1]) * HALF_SQRT3_S;
         t1d_ff <= t1_ff;
         t3_ff <= tpik_pkg::T1_W'(rr_s) * tpik_pkg::T1_W'(s3);
         l1sq_ff <= 32'(upper_arm_length_ff) * 32'(upper_arm_length_ff);
         l2sq_ff <= 32'(lower_link_length_ff) * 32'(lower_link_length_ff);
      end
   end

   // per-arm ratio, root and arctangent
   tpik_pkg::div_lane_type div_chain [3][tpik_pkg::DIV_STEPS+1];
   tpik_pkg::div_lane_type div_in [3];
   tpik_pkg::sqrt_lane_type sqrt_chain [3][tpik_pkg::SQRT_STEPS+1];
   tpik_pkg::cordic_lane_type vec_chain [3][tpik_pkg::CORDIC_STEPS+1];
   logic signed [tpik_pkg::NUM_W-1:0] num [3];
   logic signed [tpik_pkg::DEN_W-1:0] den [3];
   logic [tpik_pkg::AN_W-1:0] an [3];
   logic [tpik_pkg::AD_W-1:0] ad [3];
   logic signed [tpik_pkg::R_W-1:0] rq [3];
   logic signed [tpik_pkg::R_W-1:0] r_ff [3];
   logic signed [tpik_pkg::R_W-1:0] rd_ff [3];
   logic r_bad_ff [3];
   logic rd_bad_ff [3];
   logic [tpik_pkg::SQ_V_W-1:0] rsq_ff [3];
   logic signed [tpik_pkg::P_W-1:0] rsq_full [3];
   tpik_pkg::sqrt_lane_type sqrt_init [3];
   logic signed [OUT_Z_W-1:0] out_sum [3];
   logic signed [OUT_Z_W-1:0] out_sh [3];
   logic signed [tpik_pkg::FIELD_W-1:0] servo_sat [3];

   for (genvar a = 0; a < 3; a++) begin : g_arm
      assign num[a] = tpik_pkg::NUM_W'(sq_ff[a])
                      + tpik_pkg::NUM_W'(signed'({1'b0, l1sq_ff, 16'd0}))
                      - tpik_pkg::NUM_W'(signed'({1'b0, l2sq_ff, 16'd0}));
      assign den[a] = tpik_pkg::DEN_W'(cr_ff[a]) <<< 9;
      assign an[a] = tpik_pkg::AN_W'(num[a][tpik_pkg::NUM_W-1] ? -num[a] : num[a]);
      assign ad[a] = tpik_pkg::AD_W'(den[a][tpik_pkg::DEN_W-1] ? -den[a] : den[a]);

      always_comb begin
         div_in[a].rem = tpik_pkg::REM_W'(an[a]);
         div_in[a].den = ad[a];
         div_in[a].q = '0;
         div_in[a].neg = num[a][tpik_pkg::NUM_W-1] != den[a][tpik_pkg::DEN_W-1];
         div_in[a].full = an[a] == tpik_pkg::AN_W'(ad[a]);
         div_in[a].bad = (ad[a] == '0) || (an[a] > tpik_pkg::AN_W'(ad[a]));
      end

      always_comb begin
         rq[a] = div_chain[a][tpik_pkg::DIV_STEPS].full ? (tpik_pkg::R_W'(1) <<< 30)
                 : tpik_pkg::R_W'(div_chain[a][tpik_pkg::DIV_STEPS].q);
         if (div_chain[a][tpik_pkg::DIV_STEPS].neg) begin
            rq[a] = -rq[a];
         end
      end

      assign rsq_full[a] = tpik_pkg::P_W'(r_ff[a]) * tpik_pkg::P_W'(r_ff[a]);

      always_comb begin
         sqrt_init[a].v = (tpik_pkg::SQ_V_W'(1) << 60) - rsq_ff[a];
         sqrt_init[a].res = '0;
         sqrt_init[a].r = rd_ff[a];
         sqrt_init[a].bad = rd_bad_ff[a];
      end

      always_comb begin
         vec_chain[a][0].x = tpik_pkg::CORDIC_W'(sqrt_chain[a][tpik_pkg::SQRT_STEPS].res);
         vec_chain[a][0].y = tpik_pkg::CORDIC_W'(sqrt_chain[a][tpik_pkg::SQRT_STEPS].r);
         vec_chain[a][0].z = '0;
         vec_chain[a][0].flag = sqrt_chain[a][tpik_pkg::SQRT_STEPS].bad;
      end

      always_ff @(posedge clock) begin
         if (en) begin
            laq_ff[a] <= laq_in[a];
            la_ff[a] <= tpik_pkg::LA_W'((laq_ff[a] + tpik_pkg::LAQ_W'(1 << 21)) >>> 22);
            sq_ff[a] <= tpik_pkg::SQ_W'(la_ff[a]) * tpik_pkg::SQ_W'(la_ff[a]);
            cr_ff[a] <= tpik_pkg::CR_W'(la_ff[a])
                        * tpik_pkg::CR_W'(signed'({1'b0, upper_arm_length_ff}));
            div_chain[a][0] <= div_in[a];
            r_ff[a] <= rq[a];
            r_bad_ff[a] <= div_chain[a][tpik_pkg::DIV_STEPS].bad;
            rsq_ff[a] <= tpik_pkg::SQ_V_W'(rsq_full[a]);
            rd_ff[a] <= r_ff[a];
            rd_bad_ff[a] <= r_bad_ff[a];
            sqrt_chain[a][0] <= sqrt_init[a];
         end
      end

      for (genvar s = 0; s < tpik_pkg::DIV_STEPS; s++) begin : g_div
         tpik_div_cell u_cell (
            .clock    (clock),
            .enable   (en),
            .cell_in  (div_chain[a][s]),
            .cell_out (div_chain[a][s+1])
         );
      end

      for (genvar s = 0; s < tpik_pkg::SQRT_STEPS; s++) begin : g_sqrt
         tpik_sqrt_cell #(
            .STEP (s)
         ) u_cell (
            .clock    (clock),
            .enable   (en),
            .cell_in  (sqrt_chain[a][s]),
            .cell_out (sqrt_chain[a][s+1])
         );
      end

      for (genvar s = 0; s < tpik_pkg::CORDIC_STEPS; s++) begin : g_vec
         tpik_cordic_cell #(
            .STEP   (s),
            .VECTOR (1'b1)
         ) u_cell (
            .clock    (clock),
            .enable   (en),
            .cell_in  (vec_chain[a][s]),
            .cell_out (vec_chain[a][s+1])
         );
      end

      assign out_sum[a] = OUT_Z_W'(vec_chain[a][tpik_pkg::CORDIC_STEPS].z)
                          + OUT_Z_W'(ROUND_ADD);
      assign out_sh[a] = out_sum[a] >>> SHIFT;

      always_comb begin
         if (out_sh[a] > OUT_Z_W'(tpik_pkg::SERVO_MAX)) begin
            servo_sat[a] = tpik_pkg::SERVO_MAX;
         end else if (out_sh[a] < OUT_Z_W'(tpik_pkg::SERVO_MIN)) begin
            servo_sat[a] = tpik_pkg::SERVO_MIN;
         end else begin
            servo_sat[a] = tpik_pkg::FIELD_W'(out_sh[a]);
         end
      end
   end

   // result register
   logic any_bad;
   logic signed [tpik_pkg::FIELD_W-1:0] servo_a_ff, servo_b_ff, servo_c_ff;
   logic invalid_ff;

   assign any_bad = vec_chain[0][tpik_pkg::CORDIC_STEPS].flag
                    || vec_chain[1][tpik_pkg::CORDIC_STEPS].flag
                    || vec_chain[2][tpik_pkg::CORDIC_STEPS].flag;

   always_ff @(posedge clock) begin
      if (en) begin
         servo_a_ff <= any_bad ? '0 : servo_sat[0];
         servo_b_ff <= any_bad ? '0 : servo_sat[1];
         servo_c_ff <= any_bad ? '0 : servo_sat[2];
         invalid_ff <= any_bad;
      end
   end

   assign rsp_chan.valid = valid_ff[LATENCY-1];
   assign rsp_chan.servo_a = servo_a_ff;
   assign rsp_chan.servo_b = servo_b_ff;
   assign rsp_chan.servo_c = servo_c_ff;
   assign rsp_chan.invalid = invalid_ff;

endmodule

### design/tpik_cordic_cell.sv
// ----------------------------------------------------------------------------
// tpik_cordic_cell
// One CORDIC micro-rotation, rotation or vectoring mode, registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tpik_cordic_cell #(
   parameter int unsigned STEP = 0,
   parameter bit VECTOR = 1'b0
) (
   input  logic                       clock,
   input  logic                       enable,
   input  tpik_pkg::cordic_lane_type  cell_in,
   output tpik_pkg::cordic_lane_type  cell_out
);

   localparam logic signed [tpik_pkg::CORDIC_Z_W-1:0] ATAN = tpik_pkg::atan_deg(STEP);

   tpik_pkg::cordic_lane_type lane_ff, lane_in;
   logic signed [tpik_pkg::CORDIC_W-1:0] dx, dy;
   logic pos;

   assign dx = cell_in.y >>> STEP;
   assign dy = cell_in.x >>> STEP;
   assign pos = VECTOR ? (cell_in.y > 0) : !cell_in.z[tpik_pkg::CORDIC_Z_W-1];

   always_comb begin
      lane_in.flag = cell_in.flag;
      if (pos ^ VECTOR) begin
         lane_in.x = cell_in.x - dx;
         lane_in.y = cell_in.y + dy;
         lane_in.z = cell_in.z - ATAN;
      end else begin
         lane_in.x = cell_in.x + dx;
         lane_in.y = cell_in.y - dy;
         lane_in.z = cell_in.z + ATAN;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         lane_ff <= lane_in;
      end
   end

   assign cell_out = lane_ff;

endmodule

### design/tpik_div_cell.sv
// ----------------------------------------------------------------------------
// tpik_div_cell
// One restoring division step yielding one quotient bit, registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tpik_div_cell (
   input  logic                    clock,
   input  logic                    enable,
   input  tpik_pkg::div_lane_type  cell_in,
   output tpik_pkg::div_lane_type  cell_out
);

   tpik_pkg::div_lane_type lane_ff, lane_in;
   logic [tpik_pkg::REM_W-1:0] shifted;

   assign shifted = {cell_in.rem[tpik_pkg::REM_W-2:0], 1'b0};

   always_comb begin
      lane_in = cell_in;
      if (shifted >= {1'b0, cell_in.den}) begin
         lane_in.rem = shifted - {1'b0, cell_in.den};
         lane_in.q = {cell_in.q[tpik_pkg::Q_W-2:0], 1'b1};
      end else begin
         lane_in.rem = shifted;
         lane_in.q = {cell_in.q[tpik_pkg::Q_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         lane_ff <= lane_in;
      end
   end

   assign cell_out = lane_ff;

endmodule

### design/tpik_sqrt_cell.sv
// ----------------------------------------------------------------------------
// tpik_sqrt_cell
// One digit-pair step of the integer square root, registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tpik_sqrt_cell #(
   parameter int unsigned STEP = 0
) (
   input  logic                     clock,
   input  logic                     enable,
   input  tpik_pkg::sqrt_lane_type  cell_in,
   output tpik_pkg::sqrt_lane_type  cell_out
);

   localparam logic [tpik_pkg::SQ_RES_W-1:0] BIT =
      tpik_pkg::SQ_RES_W'(1) << (2 * (tpik_pkg::SQRT_STEPS - 1 - STEP));

   tpik_pkg::sqrt_lane_type lane_ff, lane_in;
   logic [tpik_pkg::SQ_RES_W-1:0] trial;

   assign trial = cell_in.res + BIT;

   always_comb begin
      lane_in = cell_in;
      if ({1'b0, cell_in.v} >= trial) begin
         lane_in.v = cell_in.v - trial[tpik_pkg::SQ_V_W-1:0];
         lane_in.res = (cell_in.res >> 1) + BIT;
      end else begin
         lane_in.res = cell_in.res >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         lane_ff <= lane_in;
      end
   end

   assign cell_out = lane_ff;

endmodule
